@@ rtl/core/scc_pkg.sv @@
// ----------------------------------------------------------------------------
// scc_pkg: shared definitions for the stroke corner counter
// Field widths, reset values and the turn unit status word.
// ----------------------------------------------------------------------------
package scc_pkg;

    localparam int IN_BITS        = 16;  // coordinate port width
    localparam int CFG_BITS       = 5;   // window_size register width
    localparam int COUNT_BITS     = 8;   // corner_count width
    localparam int SEEN_BITS      = 6;   // points_seen / gap counter width

    localparam int DEF_MAX_WINDOW = 16;
    localparam int DEF_COORD_BITS = 16;

    localparam logic [CFG_BITS-1:0]   WINDOW_RESET = CFG_BITS'(8);
    localparam logic [SEEN_BITS-1:0]  SEEN_MAX     = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX    = '1;
    localparam int                    DEBOUNCE_MIN = 2;

    // status from the turn unit back to the top level
    typedef struct packed {
        logic done;   // test finished this cycle
        logic sharp;  // turn is sharp (valid with done)
    } turn_res_t;

endpackage : scc_pkg

@@ rtl/core/scc_cell.sv @@
// ----------------------------------------------------------------------------
// scc_cell: one slot of the point window
// Holds one point, passes it to the next slot on a shift, and drives the
// mid / far tap buses when its position matches.
// ----------------------------------------------------------------------------
module scc_cell #(
    parameter int CW  = 16,
    parameter int DW  = 6,
    parameter int IDX = 0
) (
    input  logic          clk,
    input  logic          shift_en,
    input  logic [CW-1:0] x_in,
    input  logic [CW-1:0] y_in,
    input  logic [DW-1:0] mid_idx,
    input  logic [DW-1:0] far_idx,
    output logic [CW-1:0] x_out,
    output logic [CW-1:0] y_out,
    output logic [CW-1:0] mid_x,
    output logic [CW-1:0] mid_y,
    output logic [CW-1:0] far_x,
    output logic [CW-1:0] far_y
);

    logic [CW-1:0] x_reg;
    logic [CW-1:0] y_reg;
    logic          mid_hit;
    logic          far_hit;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            x_reg <= x_in;
            y_reg <= y_in;
        end
    end

    assign mid_hit = (mid_idx == DW'(IDX));
    assign far_hit = (far_idx == DW'(IDX));

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign mid_x = mid_hit ? x_reg : '0;
    assign mid_y = mid_hit ? y_reg : '0;
    assign far_x = far_hit ? x_reg : '0;
    assign far_y = far_hit ? y_reg : '0;

endmodule : scc_cell

@@ rtl/core/scc_turn_unit.sv @@
// ----------------------------------------------------------------------------
// scc_turn_unit: sharp turn test on three points
// One shared HxH multiplier, stepped: six products for |a|^2, |b|^2 and the
// dot product, then dot^2 and |a|^2*|b|^2 as four partial products each,
// then 100*dot^2 < 9*|a|^2*|b|^2; a zero vector or negative dot ends early.
// ----------------------------------------------------------------------------
module scc_turn_unit #(
    parameter int CW = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [CW-1:0]        p0_x,
    input  logic [CW-1:0]        p0_y,
    input  logic [CW-1:0]        p1_x,
    input  logic [CW-1:0]        p1_y,
    input  logic [CW-1:0]        p2_x,
    input  logic [CW-1:0]        p2_y,
    output scc_pkg::turn_res_t   res
);
    import scc_pkg::*;

    localparam int H  = CW + 1;   // half width of the wide operands
    localparam int PW = 2 * H;    // product / length^2 width
    localparam int AW = 4 * H;    // wide accumulator
    localparam int LW = AW + 7;   // room for the x100 scale

    localparam int COS_NUM_SQ = 9;    // 0.3^2 = 9/100
    localparam int COS_DEN_SQ = 100;

    localparam logic [4:0] ST_SQ_FIRST  = 5'd1;
    localparam logic [4:0] ST_DECIDE    = 5'd8;
    localparam logic [4:0] ST_DOT_FIRST = 5'd9;
    localparam logic [4:0] ST_SCALE     = 5'd14;
    localparam logic [4:0] ST_LEN_FIRST = 5'd15;
    localparam logic [4:0] ST_CMP       = 5'd20;

    typedef enum logic {U_IDLE, U_RUN} ustate_t;

    ustate_t              state_reg, state_next;
    logic [4:0]           step_reg, step_next;
    logic [H-1:0]         axm_reg, aym_reg, bxm_reg, bym_reg;
    logic [H-1:0]         axm_next, aym_next, bxm_next, bym_next;
    logic                 axs_reg, ays_reg, bxs_reg, bys_reg;
    logic                 axs_next, ays_next, bxs_next, bys_next;
    logic [PW-1:0]        prod_reg, prod_next;
    logic [PW-1:0]        la2_reg, la2_next;
    logic [PW-1:0]        lb2_reg, lb2_next;
    logic signed [PW:0]   dot_reg, dot_next;
    logic [PW-1:0]        mag_reg, mag_next;
    logic [AW-1:0]        acc_reg, acc_next;
    logic [LW-1:0]        lhs_reg, lhs_next;

    logic [H-1:0]         opa, opb;
    logic [4:0]           sq_iss, sq_use, dot_iss, dot_use, len_iss, len_use;
    logic [AW-1:0]        pp_shifted;
    logic [1:0]           pp_sel;
    logic signed [PW:0]   prod_ext;
    logic                 degenerate;
    logic                 dot_neg;
    logic                 cmp_less;

    function automatic logic [H:0] sub_mag(input logic [CW-1:0] hi, input logic [CW-1:0] lo);
        logic [H-1:0] d;
        d = {1'b0, hi} - {1'b0, lo};
        sub_mag = {d[H-1], (d[H-1] ? (~d + H'(1)) : d)};
    endfunction

    assign sq_iss  = step_reg - ST_SQ_FIRST;
    assign sq_use  = step_reg - ST_SQ_FIRST - 5'd1;
    assign dot_iss = step_reg - ST_DOT_FIRST;
    assign dot_use = step_reg - ST_DOT_FIRST - 5'd1;
    assign len_iss = step_reg - ST_LEN_FIRST;
    assign len_use = step_reg - ST_LEN_FIRST - 5'd1;

    assign degenerate = (la2_reg == '0) || (lb2_reg == '0);
    assign dot_neg    = dot_reg[PW];
    assign prod_ext   = $signed({1'b0, prod_reg});
    assign cmp_less   = lhs_reg < (LW'(acc_reg) * LW'(COS_NUM_SQ));

    // operand select for the shared multiplier
    always_comb
    begin
        opa = axm_reg;
        opb = axm_reg;
        if (step_reg >= ST_SQ_FIRST && step_reg < ST_DECIDE - 5'd1)
        begin
            case (sq_iss[2:0])
                3'd0:    begin opa = axm_reg; opb = axm_reg; end
                3'd1:    begin opa = aym_reg; opb = aym_reg; end
                3'd2:    begin opa = bxm_reg; opb = bxm_reg; end
                3'd3:    begin opa = bym_reg; opb = bym_reg; end
                3'd4:    begin opa = axm_reg; opb = bxm_reg; end
                default: begin opa = aym_reg; opb = bym_reg; end
            endcase
        end
        else if (step_reg >= ST_DOT_FIRST && step_reg < ST_SCALE - 5'd1)
        begin
            opa = dot_iss[1] ? mag_reg[PW-1:H] : mag_reg[H-1:0];
            opb = dot_iss[0] ? mag_reg[PW-1:H] : mag_reg[H-1:0];
        end
        else if (step_reg >= ST_LEN_FIRST && step_reg < ST_CMP - 5'd1)
        begin
            opa = len_iss[1] ? la2_reg[PW-1:H] : la2_reg[H-1:0];
            opb = len_iss[0] ? lb2_reg[PW-1:H] : lb2_reg[H-1:0];
        end
    end

    // partial product placed by its half weights
    always_comb
    begin
        pp_sel = (step_reg < ST_SCALE) ? dot_use[1:0] : len_use[1:0];
        case (pp_sel)
            2'd0:    pp_shifted = AW'(prod_reg);
            2'd3:    pp_shifted = AW'(prod_reg) << (2 * H);
            default: pp_shifted = AW'(prod_reg) << H;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        axm_next   = axm_reg;
        aym_next   = aym_reg;
        bxm_next   = bxm_reg;
        bym_next   = bym_reg;
        axs_next   = axs_reg;
        ays_next   = ays_reg;
        bxs_next   = bxs_reg;
        bys_next   = bys_reg;
        prod_next  = {{H{1'b0}}, opa} * {{H{1'b0}}, opb};
        la2_next   = la2_reg;
        lb2_next   = lb2_reg;
        dot_next   = dot_reg;
        mag_next   = mag_reg;
        acc_next   = acc_reg;
        lhs_next   = lhs_reg;
        res        = '0;

        unique case (state_reg)
            U_IDLE:
            begin
                if (start)
                begin
                    {axs_next, axm_next} = sub_mag(p1_x, p0_x);
                    {ays_next, aym_next} = sub_mag(p1_y, p0_y);
                    {bxs_next, bxm_next} = sub_mag(p2_x, p1_x);
                    {bys_next, bym_next} = sub_mag(p2_y, p1_y);
                    la2_next   = '0;
                    lb2_next   = '0;
                    dot_next   = '0;
                    step_next  = ST_SQ_FIRST;
                    state_next = U_RUN;
                end
            end
            U_RUN:
            begin
                step_next = step_reg + 5'd1;
                if (step_reg > ST_SQ_FIRST && step_reg < ST_DECIDE)
                begin
                    case (sq_use[2:0]) inside
                        3'd0, 3'd1: la2_next = la2_reg + prod_reg;
                        3'd2, 3'd3: lb2_next = lb2_reg + prod_reg;
                        3'd4:       dot_next = (axs_reg ^ bxs_reg) ? dot_reg - prod_ext
                                                                   : dot_reg + prod_ext;
                        default:    dot_next = (ays_reg ^ bys_reg) ? dot_reg - prod_ext
                                                                   : dot_reg + prod_ext;
                    endcase
                end
                if (step_reg == ST_DECIDE)
                begin
                    mag_next = dot_reg[PW-1:0];
                    acc_next = '0;
                    if (degenerate || dot_neg)
                    begin
                        res.done   = 1'b1;
                        res.sharp  = !degenerate;
                        state_next = U_IDLE;
                    end
                end
                if ((step_reg > ST_DOT_FIRST && step_reg < ST_SCALE)
                    || (step_reg > ST_LEN_FIRST && step_reg < ST_CMP))
                begin
                    acc_next = acc_reg + pp_shifted;
                end
                if (step_reg == ST_SCALE)
                begin
                    lhs_next = LW'(acc_reg) * LW'(COS_DEN_SQ);
                    acc_next = '0;
                end
                if (step_reg == ST_CMP)
                begin
                    res.done   = 1'b1;
                    res.sharp  = cmp_less;
                    state_next = U_IDLE;
                end
            end
            default:
            begin
                state_next = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        axm_reg  <= axm_next;
        aym_reg  <= aym_next;
        bxm_reg  <= bxm_next;
        bym_reg  <= bym_next;
        axs_reg  <= axs_next;
        ays_reg  <= ays_next;
        bxs_reg  <= bxs_next;
        bys_reg  <= bys_next;
        prod_reg <= prod_next;
        la2_reg  <= la2_next;
        lb2_reg  <= lb2_next;
        dot_reg  <= dot_next;
        mag_reg  <= mag_next;
        acc_reg  <= acc_next;
        lhs_reg  <= lhs_next;
    end

endmodule : scc_turn_unit

@@ rtl/core/stroke_corner_counter_core.sv @@
// ----------------------------------------------------------------------------
// stroke_corner_counter_core: counts debounced sharp turns in a swipe trace
// A row of point cells holds the last 2W+1 points; a stepped turn unit tests
// the middle point against points W behind and W ahead.
// ----------------------------------------------------------------------------
//
//  channel  | handshake              | word
//  ---------+------------------------+----------------------------------------
//  in       | in_valid / in_stall    | point_x, point_y, last_point
//  out      | out_valid / out_stall  | corner_count, trace_too_short
//  cfg      | cfg_valid / cfg_ready  | window_size (radius W)
//
//  One word at a time. A point that is not tested passes accept and load;
//  a tested point adds 20 steps of the shared multiplier, and stops at the
//  decide step when a vector has zero length or the dot product is negative.
//  A last point ends with a move of the result into the output register.
//  Reset clears the counters and the radius (to 8); window cells need none.
//  The output register lets a new point in while a result waits; only the
//  next result waits for out_stall to drop.
// ----------------------------------------------------------------------------
module stroke_corner_counter_core #(
    parameter int MAX_WINDOW = scc_pkg::DEF_MAX_WINDOW,
    parameter int COORD_BITS = scc_pkg::DEF_COORD_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [scc_pkg::IN_BITS-1:0]     point_x,
    input  logic [scc_pkg::IN_BITS-1:0]     point_y,
    input  logic                            last_point,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [scc_pkg::COUNT_BITS-1:0]  corner_count,
    output logic                            trace_too_short,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [scc_pkg::CFG_BITS-1:0]    window_size
);
    import scc_pkg::*;

    localparam int DEPTH = 2 * MAX_WINDOW + 1;
    localparam int CW    = (COORD_BITS < IN_BITS) ? COORD_BITS : IN_BITS;
    localparam int WW    = $clog2(MAX_WINDOW + 1);   // radius width
    localparam int DW    = $clog2(DEPTH);            // cell position width
    localparam int NW    = WW + 2;                   // 2W+1 width
    localparam int EW    = (WW > CFG_BITS) ? WW : CFG_BITS;
    localparam int CMPW  = (NW > SEEN_BITS) ? NW : SEEN_BITS;
    localparam int GW    = (WW > SEEN_BITS) ? WW : SEEN_BITS;

    typedef enum logic [1:0] {S_IDLE, S_LOAD, S_WAIT, S_DELIVER} state_t;

    state_t                  state_reg, state_next;
    logic [CFG_BITS-1:0]     window_size_reg, window_size_next;
    logic [WW-1:0]           w_reg, w_next;
    logic                    last_reg, last_next;
    logic                    test_reg, test_next;
    logic [SEEN_BITS-1:0]    seen_reg, seen_next;
    logic [SEEN_BITS-1:0]    gap_reg, gap_next;
    logic                    any_reg, any_next;
    logic [COUNT_BITS-1:0]   corners_reg, corners_next;
    logic                    out_valid_reg, out_valid_next;
    logic [COUNT_BITS-1:0]   out_count_reg, out_count_next;
    logic                    out_short_reg, out_short_next;

    logic                    accept;
    logic                    shift_en;
    logic [EW-1:0]           ws_ext;
    logic [EW-1:0]           w_eff;
    logic [WW-1:0]           w_now;
    logic [NW-1:0]           need_now;
    logic [SEEN_BITS-1:0]    seen_inc;
    logic [WW-1:0]           half_w;
    logic [GW-1:0]           debounce;
    logic                    corner_ok;
    logic [DW-1:0]           mid_idx;
    logic [DW-1:0]           far_idx;
    turn_res_t               turn_res;

    // window row: chain[0] is the incoming point, cell k holds window[k]
    logic [CW-1:0] chain_x [DEPTH+1];
    logic [CW-1:0] chain_y [DEPTH+1];
    logic [CW-1:0] mid_x_tap [DEPTH];
    logic [CW-1:0] mid_y_tap [DEPTH];
    logic [CW-1:0] far_x_tap [DEPTH];
    logic [CW-1:0] far_y_tap [DEPTH];
    logic [CW-1:0] mid_x, mid_y, far_x, far_y;

    assign accept   = in_valid && !in_stall;
    assign shift_en = accept;
    assign in_stall = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);

    assign chain_x[0] = point_x[CW-1:0];
    assign chain_y[0] = point_y[CW-1:0];

    assign mid_idx = DW'(w_reg);
    assign far_idx = DW'({w_reg, 1'b0});

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            scc_cell #(
                .CW  (CW),
                .DW  (DW),
                .IDX (gi)
            ) u_cell (
                .clk      (clk),
                .shift_en (shift_en),
                .x_in     (chain_x[gi]),
                .y_in     (chain_y[gi]),
                .mid_idx  (mid_idx),
                .far_idx  (far_idx),
                .x_out    (chain_x[gi+1]),
                .y_out    (chain_y[gi+1]),
                .mid_x    (mid_x_tap[gi]),
                .mid_y    (mid_y_tap[gi]),
                .far_x    (far_x_tap[gi]),
                .far_y    (far_y_tap[gi])
            );
        end
    endgenerate

    // only one cell drives each tap, so an OR collects it
    always_comb
    begin
        mid_x = '0;
        mid_y = '0;
        far_x = '0;
        far_y = '0;
        for (int k = 0; k < DEPTH; k++)
        begin
            mid_x = mid_x | mid_x_tap[k];
            mid_y = mid_y | mid_y_tap[k];
            far_x = far_x | far_x_tap[k];
            far_y = far_y | far_y_tap[k];
        end
    end

    scc_turn_unit #(
        .CW (CW)
    ) u_turn (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == S_LOAD && test_reg),
        .p0_x  (far_x),
        .p0_y  (far_y),
        .p1_x  (mid_x),
        .p1_y  (mid_y),
        .p2_x  (chain_x[1]),
        .p2_y  (chain_y[1]),
        .res   (turn_res)
    );

    // radius clamp: 0 acts as 1, above MAX_WINDOW acts as MAX_WINDOW
    always_comb
    begin
        ws_ext = EW'(window_size_reg);
        if (ws_ext == '0)
            w_eff = EW'(1);
        else if (ws_ext > EW'(MAX_WINDOW))
            w_eff = EW'(MAX_WINDOW);
        else
            w_eff = ws_ext;
    end

    assign w_now    = w_eff[WW-1:0];
    assign need_now = NW'({w_now, 1'b1});
    assign seen_inc = (seen_reg == SEEN_MAX) ? seen_reg : seen_reg + SEEN_BITS'(1);

    // debounce gap is max(2, W/2); the first corner of a trace always counts
    assign half_w    = w_reg >> 1;
    assign debounce  = (GW'(half_w) < GW'(DEBOUNCE_MIN)) ? GW'(DEBOUNCE_MIN) : GW'(half_w);
    assign corner_ok = !any_reg || (GW'(gap_reg) > debounce);

    always_comb
    begin
        state_next       = state_reg;
        window_size_next = window_size_reg;
        w_next           = w_reg;
        last_next        = last_reg;
        test_next        = test_reg;
        seen_next        = seen_reg;
        gap_next         = gap_reg;
        any_next         = any_reg;
        corners_next     = corners_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_count_next   = out_count_reg;
        out_short_next   = out_short_reg;

        if (cfg_valid && cfg_ready)
            window_size_next = window_size;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    w_next     = w_now;
                    last_next  = last_point;
                    seen_next  = seen_inc;
                    test_next  = CMPW'(seen_inc) >= CMPW'(need_now);
                    if (CMPW'(seen_inc) >= CMPW'(need_now) && any_reg && gap_reg != SEEN_MAX)
                        gap_next = gap_reg + SEEN_BITS'(1);
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (test_reg)
                    state_next = S_WAIT;
                else if (last_reg)
                    state_next = S_DELIVER;
                else
                    state_next = S_IDLE;
            end
            S_WAIT:
            begin
                if (turn_res.done)
                begin
                    if (turn_res.sharp && corner_ok)
                    begin
                        if (corners_reg != COUNT_MAX)
                            corners_next = corners_reg + COUNT_BITS'(1);
                        any_next = 1'b1;
                        gap_next = '0;
                    end
                    state_next = last_reg ? S_DELIVER : S_IDLE;
                end
            end
            S_DELIVER:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_count_next = corners_reg;
                    out_short_next = !test_reg;
                    seen_next      = '0;
                    gap_next       = '0;
                    any_next       = 1'b0;
                    corners_next   = '0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            window_size_reg <= WINDOW_RESET;
            w_reg           <= '0;
            last_reg        <= 1'b0;
            test_reg        <= 1'b0;
            seen_reg        <= '0;
            gap_reg         <= '0;
            any_reg         <= 1'b0;
            corners_reg     <= '0;
            out_valid_reg   <= 1'b0;
            out_count_reg   <= '0;
            out_short_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            window_size_reg <= window_size_next;
            w_reg           <= w_next;
            last_reg        <= last_next;
            test_reg        <= test_next;
            seen_reg        <= seen_next;
            gap_reg         <= gap_next;
            any_reg         <= any_next;
            corners_reg     <= corners_next;
            out_valid_reg   <= out_valid_next;
            out_count_reg   <= out_count_next;
            out_short_reg   <= out_short_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign corner_count    = out_count_reg;
    assign trace_too_short = out_short_reg;

endmodule : stroke_corner_counter_core

@@ rtl/core/scc_checker.sv @@
// ----------------------------------------------------------------------------
// scc_checker: port-level checks for the stroke corner counter
// Watches the handshakes and result word of the top level.
// ----------------------------------------------------------------------------
module scc_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic [scc_pkg::COUNT_BITS-1:0]  corner_count,
    input  logic                            trace_too_short,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready
);
    import scc_pkg::*;

    // a held result word keeps its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(corner_count)
                                   && $stable(trace_too_short))
        else $error("result word changed while stalled");

    // a short trace never tested a position
    a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && trace_too_short |-> corner_count == '0)
        else $error("short trace reported corners");

    // one point in flight: the input stalls right after a word is taken
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second point taken while busy");

    // radius writes only land while no point is in flight
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |-> !in_stall)
        else $error("radius write while busy");

endmodule : scc_checker

bind stroke_corner_counter_core scc_checker u_scc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .corner_count    (corner_count),
    .trace_too_short (trace_too_short),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready)
);
